/* hdl/srsw_pkg.sv */
// ----------------------------------------------------------------------------
// srsw_pkg
// Shared types, codes and constants of the selective-repeat sender window.
// ----------------------------------------------------------------------------
`default_nettype none

package srsw_pkg;

   localparam int WINDOW_CAP_DEF = 32;
   localparam int SEQ_BITS_DEF   = 16;
   localparam int TIME_BITS_DEF  = 32;

   // Q17.3 timing state, 20 bits
   localparam logic [19:0] Q3_MAX        = 20'hFFFFF;
   localparam logic [19:0] EST_RESET_Q3  = 20'd1000;   // 125 ms
   localparam logic [19:0] DEV_RESET_Q3  = 20'd2000;   // 250 ms
   localparam logic [19:0] RTO_RESET_Q3  = 20'd9120;   // 1140 ms
   localparam logic [23:0] TMO_MAX       = 24'hFFFFFF;
   localparam logic [5:0]  INIT_WIN_RESET = 6'd4;
   localparam logic [7:0]  MARGIN_RESET   = 8'd15;

   // operation codes
   localparam logic [1:0] OP_SEND  = 2'd0;
   localparam logic [1:0] OP_ACK   = 2'd1;
   localparam logic [1:0] OP_CHECK = 2'd2;

   // result kinds
   localparam logic [2:0] KIND_SENT      = 3'd0;
   localparam logic [2:0] KIND_FULL      = 3'd1;
   localparam logic [2:0] KIND_ACK_TAKEN = 3'd2;
   localparam logic [2:0] KIND_ACK_IGN   = 3'd3;
   localparam logic [2:0] KIND_RESEND    = 3'd4;
   localparam logic [2:0] KIND_NONE      = 3'd5;

   // register indexes
   localparam logic [0:0] CSR_INIT_WIN   = 1'd0;
   localparam logic [0:0] CSR_RTO_MARGIN = 1'd1;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_INFL,
      ST_SND_CMP,
      ST_SND_ADD,
      ST_ACK_OFF,
      ST_ACK_CMP,
      ST_ACK_WAIT,
      ST_ACK_EVAL,
      ST_RTT1,
      ST_RTT2,
      ST_RTT3,
      ST_RTT4,
      ST_RTT5,
      ST_RTT6,
      ST_RTT7,
      ST_RTT8,
      ST_SL_INIT,
      ST_SL_WAIT,
      ST_SL_EVAL,
      ST_GROW,
      ST_TC_INIT,
      ST_TC1_WAIT,
      ST_TC1_EVAL,
      ST_TC_HALVE,
      ST_TC2_WAIT,
      ST_TC2_EVAL,
      ST_TC2_DBL,
      ST_TC2_DL,
      ST_EMIT
   } state_type;

   // entry store write controls
   typedef struct packed {
      logic acked_we;
      logic resent_we;
      logic tmo_we;
      logic dl_we;
      logic acked;
      logic resent;
   } entry_wr_type;

   // window clamped to 1..cap
   function automatic logic [6:0] clamp_win(input logic [5:0] w, input logic [6:0] cap);
      logic [6:0] r;
      r = {1'b0, w};
      if (r == 7'd0) begin
         r = 7'd1;
      end else if (r > cap) begin
         r = cap;
      end
      return r;
   endfunction

endpackage

`default_nettype wire

/* hdl/srsw_alu.sv */
// ----------------------------------------------------------------------------
// srsw_alu
// Shared adder/subtractor used by the sequencer for the window, RTT, timeout and deadline arithmetic.
// ----------------------------------------------------------------------------
`default_nettype none

module srsw_alu
   import srsw_pkg::*;
#(
   parameter int W = 33
) (
   input  wire logic [W-1:0] a,
   input  wire logic [W-1:0] b,
   input  wire logic         sub,
   output logic      [W-1:0] y
);

   // operands are zero-extended by the caller, so y[W-1] is the borrow on sub
   assign y = sub ? (a - b) : (a + b);

endmodule

`default_nettype wire

/* hdl/srsw_entry_mem.sv */
// ----------------------------------------------------------------------------
// srsw_entry_mem
// Per-slot window entries: acked, resent, timeout, deadline. One write port,
// one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module srsw_entry_mem
   import srsw_pkg::*;
#(
   parameter int WINDOW_CAP = WINDOW_CAP_DEF,
   parameter int TIME_BITS  = TIME_BITS_DEF,
   parameter int SLOT_W     = $clog2(WINDOW_CAP)
) (
   input  wire logic                 clock,
   input  wire entry_wr_type         wr,
   input  wire logic [SLOT_W-1:0]    wr_slot,
   input  wire logic [23:0]          wr_tmo,
   input  wire logic [TIME_BITS-1:0] wr_dl,
   input  wire logic [SLOT_W-1:0]    rd_slot,
   output logic                      rd_acked,
   output logic                      rd_resent,
   output logic [23:0]               rd_tmo,
   output logic [TIME_BITS-1:0]      rd_dl
);

   logic                 acked_mem  [WINDOW_CAP];
   logic                 resent_mem [WINDOW_CAP];
   logic [23:0]          tmo_mem    [WINDOW_CAP];
   logic [TIME_BITS-1:0] dl_mem     [WINDOW_CAP];

   always_ff @(posedge clock) begin
      if (wr.acked_we) begin
         acked_mem[wr_slot] <= wr.acked;
      end
      if (wr.resent_we) begin
         resent_mem[wr_slot] <= wr.resent;
      end
      if (wr.tmo_we) begin
         tmo_mem[wr_slot] <= wr_tmo;
      end
      if (wr.dl_we) begin
         dl_mem[wr_slot] <= wr_dl;
      end
      rd_acked  <= acked_mem[rd_slot];
      rd_resent <= resent_mem[rd_slot];
      rd_tmo    <= tmo_mem[rd_slot];
      rd_dl     <= dl_mem[rd_slot];
   end

endmodule

`default_nettype wire

/* hdl/selective_repeat_sender_window_unit.sv */
// ----------------------------------------------------------------------------
// selective_repeat_sender_window_unit
// Sender side of selective-repeat ARQ with AIMD window control: sends,
// acknowledgements with RTT/deviation smoothing, and timeout resends.
// ----------------------------------------------------------------------------
//
//  channel   | handshake              | payload
//  ----------+------------------------+--------------------------------------
//  request   | start / busy           | req_operation, req_ack_seq,
//            |                        | req_rtt_sample_ms, req_now_ms
//  response  | rsp_strobe (1 cycle)   | rsp_kind, rsp_seq, rsp_deadline_ms,
//            |                        | rsp_window_now, rsp_base_seq, rsp_last
//  config    | csr_valid / csr_ready  | csr_index, csr_wdata
//
//  An item is taken when start is high and busy is low; busy falls in the
//  cycle the last response item is on the ports. The main arithmetic goes
//  through one shared adder/subtractor, entries through one registered-read
//  entry store, under a sequencer. An ack inside the window walks the slots
//  up to its offset, runs the RTT update unless an earlier slot was resent,
//  then slides the base over acked slots. A time check walks every inflight
//  slot and, when a deadline has passed, halves the window and walks again
//  to resend each unacked slot. Walks take a wait and an evaluate state per
//  slot (store read latency). Reset is synchronous; the entry store is not
//  cleared, only slots inside the window are ever read. Registers are written
//  only while idle. The receiver cannot stall results.
// ----------------------------------------------------------------------------
`default_nettype none

module selective_repeat_sender_window_unit
   import srsw_pkg::*;
#(
   parameter int WINDOW_CAP = WINDOW_CAP_DEF,
   parameter int SEQ_BITS   = SEQ_BITS_DEF,
   parameter int TIME_BITS  = TIME_BITS_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // request
   input  wire logic        start,
   output logic             busy,
   input  wire logic [1:0]  req_operation,
   input  wire logic [15:0] req_ack_seq,
   input  wire logic [15:0] req_rtt_sample_ms,
   input  wire logic [31:0] req_now_ms,
   // response
   output logic             rsp_strobe,
   output logic [2:0]       rsp_kind,
   output logic [15:0]      rsp_seq,
   output logic [31:0]      rsp_deadline_ms,
   output logic [5:0]       rsp_window_now,
   output logic [15:0]      rsp_base_seq,
   output logic             rsp_last,
   // configuration
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [0:0]  csr_index,
   input  wire logic [7:0]  csr_wdata
);

   localparam int SLOT_W = $clog2(WINDOW_CAP);
   localparam int WIN_W  = $clog2(WINDOW_CAP + 1);
   localparam int CNT_W  = $clog2(WINDOW_CAP + 1);
   localparam int MAX_SQ = (SEQ_BITS > TIME_BITS) ? SEQ_BITS : TIME_BITS;
   localparam int ALU_W  = ((MAX_SQ > 24) ? MAX_SQ : 24) + 1;

   localparam logic [6:0] CAP7 = 7'(WINDOW_CAP);

   // ---------------- state ----------------
   state_type state_ff, state_in;

   logic [1:0]           op_ff, op_in;
   logic [SEQ_BITS-1:0]  ack_ff, ack_in;
   logic [15:0]          sample_ff, sample_in;
   logic [TIME_BITS-1:0] now_ff, now_in;

   logic [SEQ_BITS-1:0]  next_seq_ff, next_seq_in;
   logic [SLOT_W-1:0]    next_slot_ff, next_slot_in;
   logic [SEQ_BITS-1:0]  base_ff, base_in;
   logic [SLOT_W-1:0]    base_slot_ff, base_slot_in;
   logic [WIN_W-1:0]     ws_ff, ws_in;
   logic [WIN_W-1:0]     rem_ff, rem_in;
   logic                 avoid_ff, avoid_in;
   logic [19:0]          est_ff, est_in;
   logic [19:0]          dev_ff, dev_in;
   logic [19:0]          rto_ff, rto_in;
   logic [5:0]           init_win_ff, init_win_in;
   logic [7:0]           margin_ff, margin_in;

   // sequencer scratch
   logic [SEQ_BITS-1:0]  inflight_ff, inflight_in;
   logic [SEQ_BITS-1:0]  off_ff, off_in;
   logic [SEQ_BITS-1:0]  walk_seq_ff, walk_seq_in;
   logic [SLOT_W-1:0]    walk_slot_ff, walk_slot_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic [CNT_W-1:0]     last_off_ff, last_off_in;
   logic                 flag_ff, flag_in;     // resent seen / deadline passed
   logic                 slid_ff, slid_in;
   logic [ALU_W-1:0]     t_ff, t_in;
   logic [ALU_W-1:0]     d_ff, d_in;
   logic [23:0]          tmo_ff, tmo_in;

   // pending result item
   logic [2:0]           kind_ff, kind_in;
   logic [SEQ_BITS-1:0]  res_seq_ff, res_seq_in;
   logic [TIME_BITS-1:0] res_dl_ff, res_dl_in;
   logic                 last_ff, last_in;

   // response registers
   logic                 rsp_strobe_ff, rsp_strobe_in;
   logic [2:0]           rsp_kind_ff, rsp_kind_in;
   logic [15:0]          rsp_seq_ff, rsp_seq_in;
   logic [31:0]          rsp_dl_ff, rsp_dl_in;
   logic [5:0]           rsp_win_ff, rsp_win_in;
   logic [15:0]          rsp_base_ff, rsp_base_in;
   logic                 rsp_last_ff, rsp_last_in;

   // shared unit and entry store
   logic [ALU_W-1:0]     alu_a, alu_b, alu_y;
   logic                 alu_sub;
   logic                 alu_borrow;
   entry_wr_type         mem_wr;
   logic [SLOT_W-1:0]    mem_wr_slot;
   logic [23:0]          mem_wr_tmo;
   logic [TIME_BITS-1:0] mem_wr_dl;
   logic                 rd_acked, rd_resent;
   logic [23:0]          rd_tmo;
   logic [TIME_BITS-1:0] rd_dl;

   // derived values
   logic [ALU_W-1:0]     sample_q3;
   logic [SEQ_BITS-1:0]  walk_seq_step, base_seq_step, next_seq_step;
   logic [SLOT_W-1:0]    walk_slot_step, base_slot_step, next_slot_step;
   logic                 cnt_at_end, cnt_at_off;
   logic [WIN_W:0]       grow_raw;
   logic [WIN_W-1:0]     grow_win, half_win, clamp_cfg;
   logic [WIN_W-1:0]     reset_win;

   function automatic logic [SEQ_BITS-1:0] seq_inc(input logic [SEQ_BITS-1:0] s);
      return s + 1'b1;
   endfunction

   // slot of s+1, where sl is the slot of s (modulo cap, restarting at 0 on wrap)
   function automatic logic [SLOT_W-1:0] slot_inc(input logic [SEQ_BITS-1:0] s,
                                                 input logic [SLOT_W-1:0] sl);
      logic [SLOT_W-1:0] r;
      if (&s) begin
         r = '0;
      end else if (sl == SLOT_W'(WINDOW_CAP - 1)) begin
         r = '0;
      end else begin
         r = sl + 1'b1;
      end
      return r;
   endfunction

   function automatic logic [19:0] sat20(input logic [ALU_W-1:0] v);
      logic [19:0] r;
      if (|v[ALU_W-1:20]) begin
         r = Q3_MAX;
      end else begin
         r = v[19:0];
      end
      return r;
   endfunction

   assign sample_q3      = ALU_W'({sample_ff, 3'b000});
   assign walk_seq_step  = seq_inc(walk_seq_ff);
   assign walk_slot_step = slot_inc(walk_seq_ff, walk_slot_ff);
   assign base_seq_step  = seq_inc(base_ff);
   assign base_slot_step = slot_inc(base_ff, base_slot_ff);
   assign next_seq_step  = seq_inc(next_seq_ff);
   assign next_slot_step = slot_inc(next_seq_ff, next_slot_ff);
   assign cnt_at_end     = (SEQ_BITS'(cnt_ff) == inflight_ff);
   assign cnt_at_off     = (SEQ_BITS'(cnt_ff) == off_ff);
   assign alu_borrow     = alu_y[ALU_W-1];

   // additive increase / doubling, capped
   always_comb begin
      if (avoid_ff) begin
         grow_raw = {1'b0, ws_ff} + 1'b1;
      end else begin
         grow_raw = {ws_ff, 1'b0};
      end
      if (grow_raw > (WIN_W + 1)'(WINDOW_CAP)) begin
         grow_win = WIN_W'(WINDOW_CAP);
      end else begin
         grow_win = grow_raw[WIN_W-1:0];
      end
   end

   // multiplicative decrease, minimum one
   assign half_win  = (ws_ff[WIN_W-1:1] == '0) ? WIN_W'(1) : (ws_ff >> 1);
   assign clamp_cfg = WIN_W'(clamp_win(csr_wdata[5:0], CAP7));
   assign reset_win = WIN_W'(clamp_win(INIT_WIN_RESET, CAP7));

   srsw_alu #(
      .W (ALU_W)
   ) u_alu (
      .a   (alu_a),
      .b   (alu_b),
      .sub (alu_sub),
      .y   (alu_y)
   );

   srsw_entry_mem #(
      .WINDOW_CAP (WINDOW_CAP),
      .TIME_BITS  (TIME_BITS),
      .SLOT_W     (SLOT_W)
   ) u_entry_mem (
      .clock     (clock),
      .wr        (mem_wr),
      .wr_slot   (mem_wr_slot),
      .wr_tmo    (mem_wr_tmo),
      .wr_dl     (mem_wr_dl),
      .rd_slot   (walk_slot_ff),
      .rd_acked  (rd_acked),
      .rd_resent (rd_resent),
      .rd_tmo    (rd_tmo),
      .rd_dl     (rd_dl)
   );

   // ---------------- next state ----------------
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_INFL;
            end
         end
         ST_INFL: begin
            case (op_ff)
               OP_SEND:  state_in = ST_SND_CMP;
               OP_ACK:   state_in = ST_ACK_OFF;
               OP_CHECK: state_in = ST_TC_INIT;
               default:  state_in = ST_EMIT;
            endcase
         end
         ST_SND_CMP:  state_in = alu_borrow ? ST_SND_ADD : ST_EMIT;
         ST_SND_ADD:  state_in = ST_EMIT;
         ST_ACK_OFF:  state_in = ST_ACK_CMP;
         ST_ACK_CMP:  state_in = alu_borrow ? ST_ACK_WAIT : ST_EMIT;
         ST_ACK_WAIT: state_in = ST_ACK_EVAL;
         ST_ACK_EVAL: begin
            if (cnt_at_off) begin
               state_in = flag_ff ? ST_SL_INIT : ST_RTT1;
            end else begin
               state_in = ST_ACK_WAIT;
            end
         end
         ST_RTT1:     state_in = ST_RTT2;
         ST_RTT2:     state_in = ST_RTT3;
         ST_RTT3:     state_in = ST_RTT4;
         ST_RTT4:     state_in = ST_RTT5;
         ST_RTT5:     state_in = ST_RTT6;
         ST_RTT6:     state_in = ST_RTT7;
         ST_RTT7:     state_in = ST_RTT8;
         ST_RTT8:     state_in = ST_SL_INIT;
         ST_SL_INIT:  state_in = ST_SL_WAIT;
         ST_SL_WAIT:  state_in = ST_SL_EVAL;
         ST_SL_EVAL: begin
            if (base_ff != next_seq_ff && rd_acked) begin
               state_in = ST_SL_WAIT;
            end else begin
               state_in = ST_GROW;
            end
         end
         ST_GROW:     state_in = ST_EMIT;
         ST_TC_INIT:  state_in = ST_TC1_WAIT;
         ST_TC1_WAIT: state_in = ST_TC1_EVAL;
         ST_TC1_EVAL: begin
            if (cnt_at_end) begin
               state_in = flag_ff ? ST_TC_HALVE : ST_EMIT;
            end else begin
               state_in = ST_TC1_WAIT;
            end
         end
         ST_TC_HALVE: state_in = ST_TC2_WAIT;
         ST_TC2_WAIT: state_in = ST_TC2_EVAL;
         ST_TC2_EVAL: state_in = rd_acked ? ST_TC2_WAIT : ST_TC2_DBL;
         ST_TC2_DBL:  state_in = ST_TC2_DL;
         ST_TC2_DL:   state_in = ST_EMIT;
         ST_EMIT:     state_in = last_ff ? ST_IDLE : ST_TC2_WAIT;
         default:     state_in = ST_IDLE;
      endcase
   end

   // ---------------- datapath control ----------------
   always_comb begin
      op_in        = op_ff;
      ack_in       = ack_ff;
      sample_in    = sample_ff;
      now_in       = now_ff;
      next_seq_in  = next_seq_ff;
      next_slot_in = next_slot_ff;
      base_in      = base_ff;
      base_slot_in = base_slot_ff;
      ws_in        = ws_ff;
      rem_in       = rem_ff;
      avoid_in     = avoid_ff;
      est_in       = est_ff;
      dev_in       = dev_ff;
      rto_in       = rto_ff;
      init_win_in  = init_win_ff;
      margin_in    = margin_ff;
      inflight_in  = inflight_ff;
      off_in       = off_ff;
      walk_seq_in  = walk_seq_ff;
      walk_slot_in = walk_slot_ff;
      cnt_in       = cnt_ff;
      last_off_in  = last_off_ff;
      flag_in      = flag_ff;
      slid_in      = slid_ff;
      t_in         = t_ff;
      d_in         = d_ff;
      tmo_in       = tmo_ff;
      kind_in      = kind_ff;
      res_seq_in   = res_seq_ff;
      res_dl_in    = res_dl_ff;
      last_in      = last_ff;
      rsp_strobe_in = 1'b0;
      rsp_kind_in   = rsp_kind_ff;
      rsp_seq_in    = rsp_seq_ff;
      rsp_dl_in     = rsp_dl_ff;
      rsp_win_in    = rsp_win_ff;
      rsp_base_in   = rsp_base_ff;
      rsp_last_in   = rsp_last_ff;
      alu_a       = '0;
      alu_b       = '0;
      alu_sub     = 1'b0;
      mem_wr      = '0;
      mem_wr_slot = walk_slot_ff;
      mem_wr_tmo  = tmo_ff;
      mem_wr_dl   = res_dl_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               op_in     = req_operation;
               ack_in    = SEQ_BITS'(req_ack_seq);
               sample_in = req_rtt_sample_ms;
               now_in    = TIME_BITS'(req_now_ms);
            end
         end
         ST_INFL: begin
            alu_a       = ALU_W'(next_seq_ff);
            alu_b       = ALU_W'(base_ff);
            alu_sub     = 1'b1;
            inflight_in = alu_y[SEQ_BITS-1:0];
            // unused operation code: nothing expired
            kind_in     = KIND_NONE;
            res_seq_in  = '0;
            res_dl_in   = '0;
            last_in     = 1'b1;
         end
         ST_SND_CMP: begin
            alu_a      = ALU_W'(inflight_ff);
            alu_b      = ALU_W'(ws_ff);
            alu_sub    = 1'b1;
            kind_in    = KIND_FULL;
            res_seq_in = next_seq_ff;
            res_dl_in  = '0;
            last_in    = 1'b1;
         end
         ST_SND_ADD: begin
            alu_a         = ALU_W'(now_ff);
            alu_b         = ALU_W'(rto_ff[19:3]);
            mem_wr        = '{acked_we: 1'b1, resent_we: 1'b1, tmo_we: 1'b1,
                              dl_we: 1'b1, acked: 1'b0, resent: 1'b0};
            mem_wr_slot   = next_slot_ff;
            mem_wr_tmo    = 24'(rto_ff[19:3]);
            mem_wr_dl     = alu_y[TIME_BITS-1:0];
            kind_in       = KIND_SENT;
            res_seq_in    = next_seq_ff;
            res_dl_in     = alu_y[TIME_BITS-1:0];
            last_in       = 1'b1;
            next_seq_in   = next_seq_step;
            next_slot_in  = next_slot_step;
         end
         ST_ACK_OFF: begin
            alu_a   = ALU_W'(ack_ff);
            alu_b   = ALU_W'(base_ff);
            alu_sub = 1'b1;
            off_in  = alu_y[SEQ_BITS-1:0];
         end
         ST_ACK_CMP: begin
            alu_a        = ALU_W'(off_ff);
            alu_b        = ALU_W'(inflight_ff);
            alu_sub      = 1'b1;
            kind_in      = KIND_ACK_IGN;
            res_seq_in   = ack_ff;
            res_dl_in    = '0;
            last_in      = 1'b1;
            walk_seq_in  = base_ff;
            walk_slot_in = base_slot_ff;
            cnt_in       = '0;
            flag_in      = 1'b0;
         end
         ST_ACK_WAIT: begin
         end
         ST_ACK_EVAL: begin
            if (cnt_at_off) begin
               mem_wr = '{acked_we: 1'b1, resent_we: 1'b0, tmo_we: 1'b0,
                          dl_we: 1'b0, acked: 1'b1, resent: 1'b0};
            end else begin
               if (rd_resent) begin
                  flag_in = 1'b1;
               end
               walk_seq_in  = walk_seq_step;
               walk_slot_in = walk_slot_step;
               cnt_in       = cnt_ff + 1'b1;
            end
         end
         // smoothed RTT: dev' = (3dev + |S-est|)/4, est' = (7est + S)/8
         ST_RTT1: begin
            alu_a   = sample_q3;
            alu_b   = ALU_W'(est_ff);
            alu_sub = 1'b1;
            t_in    = alu_y;
         end
         ST_RTT2: begin
            alu_a   = ALU_W'(est_ff);
            alu_b   = sample_q3;
            alu_sub = 1'b1;
            d_in    = t_ff[ALU_W-1] ? alu_y : t_ff;
         end
         ST_RTT3: begin
            alu_a = ALU_W'(dev_ff);
            alu_b = ALU_W'({dev_ff, 1'b0});
            t_in  = alu_y;
         end
         ST_RTT4: begin
            alu_a  = t_ff;
            alu_b  = d_ff;
            dev_in = sat20(alu_y >> 2);
         end
         ST_RTT5: begin
            alu_a   = ALU_W'({est_ff, 3'b000});
            alu_b   = ALU_W'(est_ff);
            alu_sub = 1'b1;
            t_in    = alu_y;
         end
         ST_RTT6: begin
            alu_a  = t_ff;
            alu_b  = sample_q3;
            est_in = sat20(alu_y >> 3);
         end
         ST_RTT7: begin
            alu_a = ALU_W'(est_ff);
            alu_b = ALU_W'({dev_ff, 2'b00});
            t_in  = alu_y;
         end
         ST_RTT8: begin
            alu_a  = t_ff;
            alu_b  = ALU_W'({margin_ff, 3'b000});
            rto_in = sat20(alu_y);
         end
         ST_SL_INIT: begin
            walk_seq_in  = base_ff;
            walk_slot_in = base_slot_ff;
            slid_in      = 1'b0;
         end
         ST_SL_WAIT: begin
         end
         ST_SL_EVAL: begin
            if (base_ff != next_seq_ff && rd_acked) begin
               base_in      = base_seq_step;
               base_slot_in = base_slot_step;
               walk_seq_in  = base_seq_step;
               walk_slot_in = base_slot_step;
               slid_in      = 1'b1;
               if (rem_ff != '0) begin
                  rem_in = rem_ff - 1'b1;
               end
            end
         end
         ST_GROW: begin
            if (slid_ff && rem_ff == '0) begin
               ws_in  = grow_win;
               rem_in = grow_win;
            end
            kind_in    = KIND_ACK_TAKEN;
            res_seq_in = ack_ff;
            res_dl_in  = '0;
            last_in    = 1'b1;
         end
         ST_TC_INIT: begin
            walk_seq_in  = base_ff;
            walk_slot_in = base_slot_ff;
            cnt_in       = '0;
            last_off_in  = '0;
            flag_in      = 1'b0;
         end
         ST_TC1_WAIT: begin
         end
         ST_TC1_EVAL: begin
            kind_in    = KIND_NONE;
            res_seq_in = '0;
            res_dl_in  = '0;
            last_in    = 1'b1;
            if (!cnt_at_end) begin
               alu_a   = ALU_W'(now_ff);
               alu_b   = ALU_W'(rd_dl);
               alu_sub = 1'b1;
               if (!rd_acked) begin
                  last_off_in = cnt_ff;
                  // deadline passed: wrapped difference in the lower half
                  if (!alu_y[TIME_BITS-1]) begin
                     flag_in = 1'b1;
                  end
               end
               walk_seq_in  = walk_seq_step;
               walk_slot_in = walk_slot_step;
               cnt_in       = cnt_ff + 1'b1;
            end
         end
         ST_TC_HALVE: begin
            ws_in        = half_win;
            rem_in       = half_win;
            avoid_in     = 1'b1;
            walk_seq_in  = base_ff;
            walk_slot_in = base_slot_ff;
            cnt_in       = '0;
         end
         ST_TC2_WAIT: begin
         end
         ST_TC2_EVAL: begin
            if (rd_acked) begin
               walk_seq_in  = walk_seq_step;
               walk_slot_in = walk_slot_step;
               cnt_in       = cnt_ff + 1'b1;
            end
         end
         ST_TC2_DBL: begin
            alu_a = ALU_W'(rd_tmo);
            alu_b = ALU_W'(rd_tmo);
            if (|alu_y[ALU_W-1:24]) begin
               tmo_in = TMO_MAX;
            end else begin
               tmo_in = alu_y[23:0];
            end
         end
         ST_TC2_DL: begin
            alu_a      = ALU_W'(now_ff);
            alu_b      = ALU_W'(tmo_ff);
            mem_wr     = '{acked_we: 1'b0, resent_we: 1'b1, tmo_we: 1'b1,
                           dl_we: 1'b1, acked: 1'b0, resent: 1'b1};
            mem_wr_tmo = tmo_ff;
            mem_wr_dl  = alu_y[TIME_BITS-1:0];
            kind_in    = KIND_RESEND;
            res_seq_in = walk_seq_ff;
            res_dl_in  = alu_y[TIME_BITS-1:0];
            last_in    = (cnt_ff == last_off_ff);
         end
         ST_EMIT: begin
            rsp_strobe_in = 1'b1;
            rsp_kind_in   = kind_ff;
            rsp_seq_in    = 16'(res_seq_ff);
            rsp_dl_in     = 32'(res_dl_ff);
            rsp_win_in    = 6'(ws_ff);
            rsp_base_in   = 16'(base_ff);
            rsp_last_in   = last_ff;
            if (!last_ff) begin
               walk_seq_in  = walk_seq_step;
               walk_slot_in = walk_slot_step;
               cnt_in       = cnt_ff + 1'b1;
            end
         end
         default: begin
         end
      endcase

      // register writes, only while idle
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_INIT_WIN: begin
               init_win_in = csr_wdata[5:0];
               ws_in       = clamp_cfg;
               rem_in      = clamp_cfg;
            end
            CSR_RTO_MARGIN: begin
               margin_in = csr_wdata;
            end
            default: begin
            end
         endcase
      end
   end

   // ---------------- registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         next_seq_ff   <= '0;
         next_slot_ff  <= '0;
         base_ff       <= '0;
         base_slot_ff  <= '0;
         ws_ff         <= reset_win;
         rem_ff        <= reset_win;
         avoid_ff      <= 1'b0;
         est_ff        <= EST_RESET_Q3;
         dev_ff        <= DEV_RESET_Q3;
         rto_ff        <= RTO_RESET_Q3;
         init_win_ff   <= INIT_WIN_RESET;
         margin_ff     <= MARGIN_RESET;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         next_seq_ff   <= next_seq_in;
         next_slot_ff  <= next_slot_in;
         base_ff       <= base_in;
         base_slot_ff  <= base_slot_in;
         ws_ff         <= ws_in;
         rem_ff        <= rem_in;
         avoid_ff      <= avoid_in;
         est_ff        <= est_in;
         dev_ff        <= dev_in;
         rto_ff        <= rto_in;
         init_win_ff   <= init_win_in;
         margin_ff     <= margin_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      ack_ff       <= ack_in;
      sample_ff    <= sample_in;
      now_ff       <= now_in;
      inflight_ff  <= inflight_in;
      off_ff       <= off_in;
      walk_seq_ff  <= walk_seq_in;
      walk_slot_ff <= walk_slot_in;
      cnt_ff       <= cnt_in;
      last_off_ff  <= last_off_in;
      flag_ff      <= flag_in;
      slid_ff      <= slid_in;
      t_ff         <= t_in;
      d_ff         <= d_in;
      tmo_ff       <= tmo_in;
      kind_ff      <= kind_in;
      res_seq_ff   <= res_seq_in;
      res_dl_ff    <= res_dl_in;
      last_ff      <= last_in;
      rsp_kind_ff  <= rsp_kind_in;
      rsp_seq_ff   <= rsp_seq_in;
      rsp_dl_ff    <= rsp_dl_in;
      rsp_win_ff   <= rsp_win_in;
      rsp_base_ff  <= rsp_base_in;
      rsp_last_ff  <= rsp_last_in;
   end

   // ---------------- outputs ----------------
   assign busy            = (state_ff != ST_IDLE);
   assign csr_ready       = !busy;
   assign rsp_strobe      = rsp_strobe_ff;
   assign rsp_kind        = rsp_kind_ff;
   assign rsp_seq         = rsp_seq_ff;
   assign rsp_deadline_ms = rsp_dl_ff;
   assign rsp_window_now  = rsp_win_ff;
   assign rsp_base_seq    = rsp_base_ff;
   assign rsp_last        = rsp_last_ff;

endmodule

`default_nettype wire

/* verif/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the selective-repeat sender window: a directed
// table followed by random send/ack/time-check/unused-code traffic over several register
// settings, every response checked against a cycle-free window predictor.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
   import srsw_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CAP        = 32;
   localparam int WDOG_LIMIT = 4000;   // covers the longest step plus the largest gap between items
   localparam int RAND_ITEMS = 400;

   // one response item
   typedef struct {
      logic [2:0]  kind;
      logic [15:0] seq;
      logic [31:0] deadline;
      logic [5:0]  window;
      logic [15:0] base_seq;
      logic        last;
   } rsp_t;

   // one row of the directed table; chk marks a kind/seq that is typed in
   typedef struct {
      logic [1:0]  op;
      logic [15:0] ack;
      logic [15:0] sample;
      logic [31:0] now;
      bit          chk;
      logic [2:0]  kind;
      logic [15:0] seq;
   } row_t;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic [1:0]  req_operation = '0;
   logic [15:0] req_ack_seq = '0;
   logic [15:0] req_rtt_sample_ms = '0;
   logic [31:0] req_now_ms = '0;
   logic        csr_valid = 1'b0;
   logic [0:0]  csr_index = '0;
   logic [7:0]  csr_wdata = '0;
   wire         busy, csr_ready;
   wire         rsp_strobe, rsp_last;
   wire  [2:0]  rsp_kind;
   wire  [15:0] rsp_seq, rsp_base_seq;
   wire  [31:0] rsp_deadline_ms;
   wire  [5:0]  rsp_window_now;

   selective_repeat_sender_window_unit u_dut (
      .clock(clock), .reset(reset),
      .start(start), .busy(busy),
      .req_operation(req_operation), .req_ack_seq(req_ack_seq),
      .req_rtt_sample_ms(req_rtt_sample_ms), .req_now_ms(req_now_ms),
      .rsp_strobe(rsp_strobe), .rsp_kind(rsp_kind), .rsp_seq(rsp_seq),
      .rsp_deadline_ms(rsp_deadline_ms), .rsp_window_now(rsp_window_now),
      .rsp_base_seq(rsp_base_seq), .rsp_last(rsp_last),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // Predictor state: a private copy of the window and its registers
   // ---------------------------------------------------------------------
   logic [5:0]  win_init_reg;
   logic [7:0]  margin_reg;
   logic [15:0] w_next, w_base;
   logic [6:0]  w_size, w_remain;
   bit          w_avoid;
   logic [19:0] w_est, w_dev, w_rto;
   bit          e_acked  [CAP];
   bit          e_resent [CAP];
   logic [23:0] e_tmo    [CAP];
   logic [31:0] e_dl     [CAP];

   rsp_t pending_rsp_q[$];

   int unsigned items_in, rsp_seen, mismatches, resends_seen, fulls_seen;
   int unsigned idle_cycles;
   bit          accepted_now;

   function automatic logic [6:0] fit_window(input logic [5:0] w);
      if (w == 0) return 7'd1;
      if (w > CAP) return 7'(CAP);
      return {1'b0, w};
   endfunction

   task automatic window_reset();
      win_init_reg = INIT_WIN_RESET;
      margin_reg   = MARGIN_RESET;
      w_next = '0;
      w_base = '0;
      w_size = fit_window(win_init_reg);
      w_remain = w_size;
      w_avoid = 0;
      w_est = EST_RESET_Q3;
      w_dev = DEV_RESET_Q3;
      w_rto = RTO_RESET_Q3;
      for (int k = 0; k < CAP; k++) begin
         e_acked[k] = 0; e_resent[k] = 0; e_tmo[k] = '0; e_dl[k] = '0;
      end
   endtask

   // smoothed RTT, deviation and RTO, all Q3 and saturating at 20 bits
   task automatic rtt_smooth(input logic [15:0] sample);
      longint unsigned s, d, dv, es, r;
      s  = longint'(sample) * 8;
      d  = (s > w_est) ? s - w_est : w_est - s;
      dv = (3 * longint'(w_dev) + d) >> 2;
      es = (7 * longint'(w_est) + s) >> 3;
      w_dev = (dv > Q3_MAX) ? Q3_MAX : dv[19:0];
      w_est = (es > Q3_MAX) ? Q3_MAX : es[19:0];
      r = longint'(w_est) + 4 * longint'(w_dev) + 8 * longint'(margin_reg);
      w_rto = (r > Q3_MAX) ? Q3_MAX : r[19:0];
   endtask

   // one accepted item: update the window copy and queue its responses
   task automatic window_step(input logic [1:0] op, input logic [15:0] ack,
                              input logic [15:0] sample, input logic [31:0] now);
      logic [15:0] inflight, off, sq;
      logic [31:0] t;
      int          e;
      bit          prior_resend, slid, expired;
      rsp_t        r;
      rsp_t        outs[$];
      inflight = w_next - w_base;
      r = '{kind: KIND_NONE, seq: '0, deadline: '0, window: '0, base_seq: '0, last: 0};
      if (op == OP_SEND) begin
         if (inflight >= w_size) begin
            r.kind = KIND_FULL; r.seq = w_next;
         end else begin
            e = w_next % CAP;
            e_acked[e] = 0;
            e_resent[e] = 0;
            e_tmo[e] = 24'(w_rto >> 3);
            e_dl[e] = now + 32'(e_tmo[e]);
            r.kind = KIND_SENT; r.seq = w_next; r.deadline = e_dl[e];
            w_next = w_next + 1;
         end
         outs.push_back(r);
      end else if (op == OP_ACK) begin
         off = ack - w_base;
         r.seq = ack;
         if (off >= inflight) begin
            r.kind = KIND_ACK_IGN;
         end else begin
            prior_resend = 0;
            slid = 0;
            for (int i = 0; i < off; i++)
               if (e_resent[16'(w_base + i) % CAP]) prior_resend = 1;
            e_acked[ack % CAP] = 1;
            if (!prior_resend) rtt_smooth(sample);
            while (w_base != w_next && e_acked[w_base % CAP]) begin
               w_base = w_base + 1;
               if (w_remain > 0) w_remain = w_remain - 1;
               slid = 1;
            end
            if (slid && w_remain == 0) begin
               w_size = w_avoid ? w_size + 1 : w_size * 2;
               if (w_size > CAP) w_size = CAP;
               w_remain = w_size;
            end
            r.kind = KIND_ACK_TAKEN;
         end
         outs.push_back(r);
      end else if (op == OP_CHECK) begin
         expired = 0;
         for (int i = 0; i < inflight; i++) begin
            e = 16'(w_base + i) % CAP;
            t = now - e_dl[e];
            if (!e_acked[e] && !t[31]) expired = 1;
         end
         if (expired) begin
            w_size = w_size / 2;
            if (w_size < 1) w_size = 1;
            w_remain = w_size;
            w_avoid = 1;
            for (int i = 0; i < inflight && outs.size() < CAP; i++) begin
               e = 16'(w_base + i) % CAP;
               if (!e_acked[e]) begin
                  e_tmo[e] = (e_tmo[e] > (TMO_MAX >> 1)) ? TMO_MAX : e_tmo[e] * 2;
                  e_dl[e] = now + 32'(e_tmo[e]);
                  e_resent[e] = 1;
                  sq = w_base + i;
                  r.kind = KIND_RESEND; r.seq = sq; r.deadline = e_dl[e];
                  outs.push_back(r);
               end
            end
         end else begin
            outs.push_back(r);
         end
      end else begin
         outs.push_back(r);   // unused code reads as nothing expired
      end
      // window and base are reported as they stand after the whole step
      foreach (outs[k]) begin
         outs[k].window = w_size[5:0];
         outs[k].base_seq = w_base;
         outs[k].last = (k == outs.size() - 1);
         pending_rsp_q.push_back(outs[k]);
      end
   endtask

   // ---------------------------------------------------------------------
   // Response checker and watchdog, sampled at the rising edge
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      rsp_t x;
      accepted_now = !reset && start && !busy;
      if (!reset && rsp_strobe) begin
         rsp_seen++;
         if (rsp_kind == KIND_RESEND) resends_seen++;
         if (rsp_kind == KIND_FULL) fulls_seen++;
         if (pending_rsp_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("ERROR: unexpected response kind=%0d seq=%0d", rsp_kind, rsp_seq);
         end else begin
            x = pending_rsp_q.pop_front();
            if (rsp_kind !== x.kind || rsp_seq !== x.seq || rsp_deadline_ms !== x.deadline
                || rsp_window_now !== x.window || rsp_base_seq !== x.base_seq
                || rsp_last !== x.last) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("ERROR: rsp %0d exp k=%0d s=%0d d=%0d w=%0d b=%0d l=%0d got k=%0d s=%0d d=%0d w=%0d b=%0d l=%0d",
                           rsp_seen, x.kind, x.seq, x.deadline, x.window, x.base_seq, x.last,
                           rsp_kind, rsp_seq, rsp_deadline_ms, rsp_window_now,
                           rsp_base_seq, rsp_last);
            end
         end
      end
      // no progress on either side for too long means a hang
      if (reset || accepted_now || rsp_strobe || csr_valid) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= WDOG_LIMIT) begin
            $display("TIMEOUT: no item moved for %0d cycles", WDOG_LIMIT);
            $display("Some tests failed");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Drivers: all inputs change at the falling edge
   // ---------------------------------------------------------------------
   bit burst;   // stretch with no gaps between items

   task automatic issue_item(input row_t rw);
      int gap;
      @(negedge clock);
      start <= 1'b1;
      req_operation <= rw.op;
      req_ack_seq <= rw.ack;
      req_rtt_sample_ms <= rw.sample;
      req_now_ms <= rw.now;
      do @(posedge clock); while (busy);
      items_in++;
      window_step(rw.op, rw.ack, rw.sample, rw.now);
      if (rw.chk) begin
         // typed-in expectation replaces the predicted code of a one-item step
         pending_rsp_q[$].kind = rw.kind;
         pending_rsp_q[$].seq = rw.seq;
      end
      gap = burst ? 0 : $urandom_range(0, 14);
      if (gap > 0) begin
         @(negedge clock);
         start <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   // wait for the block to drain, then write one register
   task automatic csr_write(input logic [0:0] idx, input logic [7:0] val);
      @(negedge clock);
      start <= 1'b0;
      while (pending_rsp_q.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      if (idx == CSR_INIT_WIN) begin
         win_init_reg = val[5:0];
         w_size = fit_window(win_init_reg);
         w_remain = w_size;
      end else begin
         margin_reg = val;
      end
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // random traffic: mostly in-window acks and sends, now moving forward
   task automatic random_phase(input int n);
      row_t        rw;
      logic [31:0] clk_ms;
      logic [15:0] infl;
      int          pick;
      clk_ms = $urandom();
      for (int k = 0; k < n; k++) begin
         if (k % 20 == 0) burst = ($urandom_range(0, 3) == 0);
         clk_ms = clk_ms + $urandom_range(0, 300);
         if ($urandom_range(0, 30) == 0) clk_ms = clk_ms + $urandom_range(1000, 40000);
         rw = '{op: OP_SEND, ack: '0, sample: 16'($urandom_range(0, 2500)),
                now: clk_ms, chk: 0, kind: '0, seq: '0};
         if ($urandom_range(0, 40) == 0) rw.now = $urandom();
         if ($urandom_range(0, 10) == 0) rw.sample = $urandom();
         infl = w_next - w_base;
         pick = $urandom_range(0, 99);
         if (pick < 40) begin
            rw.op = OP_SEND;
            rw.ack = $urandom();
         end else if (pick < 80) begin
            rw.op = OP_ACK;
            if (infl != 0 && $urandom_range(0, 9) != 0)
               rw.ack = w_base + 16'($urandom_range(0, infl - 1));
            else
               rw.ack = $urandom();
         end else if (pick < 97) begin
            rw.op = OP_CHECK;
         end else begin
            rw.op = 2'd3;
         end
         issue_item(rw);
      end
   endtask

   row_t dir_tbl[] = '{
      '{OP_CHECK, 16'd0,     16'd0,     32'd0,          1, KIND_NONE,    16'd0},
      '{OP_ACK,   16'd0,     16'd100,   32'd0,          1, KIND_ACK_IGN, 16'd0},
      '{2'd3,     16'hFFFF,  16'hFFFF,  32'hFFFFFFFF,   1, KIND_NONE,    16'd0},
      '{OP_SEND,  16'd0,     16'd0,     32'd0,          1, KIND_SENT,    16'd0},
      '{OP_SEND,  16'd0,     16'd0,     32'd10,         1, KIND_SENT,    16'd1},
      '{OP_SEND,  16'd0,     16'd0,     32'hFFFFFFFF,   1, KIND_SENT,    16'd2},
      '{OP_SEND,  16'd0,     16'd0,     32'd20,         1, KIND_SENT,    16'd3},
      '{OP_SEND,  16'd0,     16'd0,     32'd30,         1, KIND_FULL,    16'd4},
      '{OP_ACK,   16'd1,     16'd0,     32'd40,         1, KIND_ACK_TAKEN, 16'd1},
      '{OP_ACK,   16'd1,     16'd50,    32'd41,         1, KIND_ACK_TAKEN, 16'd1},
      '{OP_ACK,   16'd0,     16'hFFFF,  32'd50,         1, KIND_ACK_TAKEN, 16'd0},
      '{OP_CHECK, 16'd0,     16'd0,     32'd5,          0, '0, '0},
      '{OP_CHECK, 16'd0,     16'd0,     32'd50000,      0, '0, '0},
      '{OP_ACK,   16'd3,     16'd300,   32'd50100,      0, '0, '0},
      '{OP_ACK,   16'd2,     16'd300,   32'd50200,      0, '0, '0},
      '{OP_ACK,   16'hFFFF,  16'd1,     32'd50300,      1, KIND_ACK_IGN, 16'hFFFF},
      '{OP_SEND,  16'd0,     16'd0,     32'h7FFFFFFF,   0, '0, '0},
      '{OP_SEND,  16'd0,     16'd0,     32'h80000000,   0, '0, '0},
      '{OP_CHECK, 16'd0,     16'd0,     32'h7FFFFFFF,   0, '0, '0},
      '{OP_CHECK, 16'd0,     16'd0,     32'hFFFF0000,   0, '0, '0},
      '{OP_ACK,   16'd4,     16'd1000,  32'hFFFF0010,   0, '0, '0},
      '{OP_ACK,   16'd5,     16'd0,     32'hFFFF0020,   0, '0, '0}
   };

   initial begin
      items_in = 0; rsp_seen = 0; mismatches = 0; resends_seen = 0; fulls_seen = 0;
      idle_cycles = 0; burst = 0;
      window_reset();
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (dir_tbl[i]) issue_item(dir_tbl[i]);

      // settings walk: widest window with the largest margin, then the
      // narrowest, then out-of-range codes that clamp, then random
      csr_write(CSR_INIT_WIN, 8'd32);
      csr_write(CSR_RTO_MARGIN, 8'hFF);
      random_phase(RAND_ITEMS / 4);
      csr_write(CSR_INIT_WIN, 8'd1);
      csr_write(CSR_RTO_MARGIN, 8'h00);
      random_phase(RAND_ITEMS / 4);
      csr_write(CSR_INIT_WIN, 8'hFF);   // 63 clamps to the cap
      csr_write(CSR_RTO_MARGIN, 8'h55);
      random_phase(RAND_ITEMS / 4);
      csr_write(CSR_INIT_WIN, 8'hC0);   // low bits zero clamp to one
      random_phase(10);
      csr_write(CSR_INIT_WIN, 8'($urandom_range(0, 255)));
      csr_write(CSR_RTO_MARGIN, 8'($urandom_range(0, 255)));
      random_phase(RAND_ITEMS / 4);

      @(negedge clock);
      start <= 1'b0;
      while (pending_rsp_q.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);

      $display("Run covered %0d items and %0d responses (%0d resends, %0d window-full).",
               items_in, rsp_seen, resends_seen, fulls_seen);
      $display("Register settings swept across window and margin extremes; %0d mismatches.",
               mismatches);
      if (mismatches == 0 && pending_rsp_q.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

`default_nettype wire
